[src/tpdsp_pkg.sv]
// Package for the tape pulse sample packer: codes, control word type and microcode table.
package tpdsp_pkg;

	localparam int MAX_CHUNKS_DEF = 56;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SAMPLE_BITS = 2'd0;
	localparam logic [1:0] REG_MACHINE_TAG = 2'd1;
	localparam logic [1:0] REG_VIDEO_TAG   = 2'd2;
	localparam logic [1:0] REG_SAMPLE_RATE = 2'd3;

	// Header word selects
	localparam logic [2:0] HDR_SIG0  = 3'd0;
	localparam logic [2:0] HDR_SIG1  = 3'd1;
	localparam logic [2:0] HDR_SIG2  = 3'd2;
	localparam logic [2:0] HDR_TAGS  = 3'd3;
	localparam logic [2:0] HDR_RATE  = 3'd4;

	localparam logic [31:0] SIG_WORD0 = 32'h4E32_4344;
	localparam logic [31:0] SIG_WORD1 = 32'h5041_542D;
	localparam logic [31:0] SIG_WORD2 = 32'h5741_522D;

	localparam logic [2:0] HDR_BYTES = 3'd4;

	typedef enum logic [1:0] {
		OP_ACCEPT,
		OP_HDR,
		OP_SAMPLE
	} op_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_HDR_DONE,
		COND_MORE
	} cond_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] hdr_sel;
		logic       hdr_end;
		cond_t      cond;
		step_t      jump;
		step_t      next;
	} ucode_t;

	typedef struct packed {
		logic slot_free;
		logic more;
		logic header_done;
	} dp_status_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_HDR0   = 3'd1;
	localparam step_t STEP_HDR1   = 3'd2;
	localparam step_t STEP_HDR2   = 3'd3;
	localparam step_t STEP_HDR3   = 3'd4;
	localparam step_t STEP_HDR4   = 3'd5;
	localparam step_t STEP_SAMPLE = 3'd6;

	// Microcode ROM: condition true takes jump, otherwise next
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			STEP_IDLE:   w = '{OP_ACCEPT, HDR_SIG0, 1'b0, COND_HDR_DONE, STEP_SAMPLE, STEP_HDR0};
			STEP_HDR0:   w = '{OP_HDR, HDR_SIG0, 1'b0, COND_ALWAYS, STEP_HDR1, STEP_HDR1};
			STEP_HDR1:   w = '{OP_HDR, HDR_SIG1, 1'b0, COND_ALWAYS, STEP_HDR2, STEP_HDR2};
			STEP_HDR2:   w = '{OP_HDR, HDR_SIG2, 1'b0, COND_ALWAYS, STEP_HDR3, STEP_HDR3};
			STEP_HDR3:   w = '{OP_HDR, HDR_TAGS, 1'b0, COND_ALWAYS, STEP_HDR4, STEP_HDR4};
			STEP_HDR4:   w = '{OP_HDR, HDR_RATE, 1'b1, COND_ALWAYS, STEP_SAMPLE, STEP_SAMPLE};
			STEP_SAMPLE: w = '{OP_SAMPLE, HDR_SIG0, 1'b0, COND_MORE, STEP_SAMPLE, STEP_IDLE};
			default:     w = '{OP_ACCEPT, HDR_SIG0, 1'b0, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

[src/tpdsp_seq.sv]
// Step counter and microcode fetch for the tape pulse sample packer.
module tpdsp_seq import tpdsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output ucode_t     ctl,
	output logic       fire
);

	step_t step_q;
	logic  cond_true;

	assign ctl = ucode_rom(step_q);

	// accept step waits on the input, emit steps on a free output slot
	assign fire = (ctl.op == OP_ACCEPT) ? in_valid : status.slot_free;

	always_comb begin
		case (ctl.cond)
			COND_ALWAYS:   cond_true = 1'b1;
			COND_HDR_DONE: cond_true = status.header_done;
			COND_MORE:     cond_true = status.more;
			default:       cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (fire) begin
			step_q <= cond_true ? ctl.jump : ctl.next;
		end
	end

endmodule

[src/tpdsp_dp.sv]
// Datapath: config registers, remainder and chunk counter, output word register.
module tpdsp_dp import tpdsp_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [31:0] pulse_length,
	input  ucode_t      ctl,
	input  logic        fire,
	input  logic        out_ready,
	output dp_status_t  status,
	output logic        out_valid,
	output logic [31:0] word_data,
	output logic [2:0]  byte_count,
	output logic        is_header,
	output logic        last_word,
	output logic        truncated
);

	localparam int CNT_W = $clog2(MAX_CHUNKS);
	localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_CHUNKS - 1);

	logic [5:0]       sample_bits_q;
	logic [1:0]       machine_tag_q;
	logic [6:0]       video_tag_q;
	logic [31:0]      sample_rate_q;
	logic             header_done_q;
	logic [31:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [31:0]      word_q;
	logic [2:0]       bytes_q;
	logic             hdr_q;
	logic             last_q;
	logic             trunc_q;

	logic [5:0]  eff_bits;
	logic [31:0] ov;
	logic [2:0]  nbytes;
	logic        ge;
	logic        at_lim;
	logic        more;
	logic [31:0] hdr_word;
	logic        emit;

	always_comb begin
		if (sample_bits_q == 6'd0)
			eff_bits = 6'd1;
		else if (sample_bits_q > 6'd32)
			eff_bits = 6'd32;
		else
			eff_bits = sample_bits_q;
	end

	assign ov     = 32'hFFFF_FFFF >> (6'd32 - eff_bits);
	assign nbytes = 3'((eff_bits + 6'd7) >> 3);
	assign ge     = rem_q >= ov;
	assign at_lim = cnt_q == CNT_LIM;
	assign more   = ge && !at_lim;

	always_comb begin
		case (ctl.hdr_sel)
			HDR_SIG0: hdr_word = SIG_WORD0;
			HDR_SIG1: hdr_word = SIG_WORD1;
			HDR_SIG2: hdr_word = SIG_WORD2;
			HDR_TAGS: hdr_word = {2'b00, eff_bits, 1'b0, video_tag_q, 6'b0, machine_tag_q, 8'h00};
			HDR_RATE: hdr_word = sample_rate_q;
			default:  hdr_word = '0;
		endcase
	end

	assign emit = fire && (ctl.op != OP_ACCEPT);

	assign status = '{slot_free: !out_valid_q || out_ready, more: more,
		header_done: header_done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q <= 6'd16;
			machine_tag_q <= '0;
			video_tag_q   <= '0;
			sample_rate_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_BITS: sample_bits_q <= cfg_data[5:0];
				REG_MACHINE_TAG: machine_tag_q <= cfg_data[1:0];
				REG_VIDEO_TAG:   video_tag_q   <= cfg_data[6:0];
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_done_q <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire && ctl.op == OP_HDR && ctl.hdr_end)
				header_done_q <= 1'b1;
			if (fire && ctl.op == OP_ACCEPT)
				cnt_q <= '0;
			else if (fire && ctl.op == OP_SAMPLE && more)
				cnt_q <= cnt_q + CNT_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.op == OP_ACCEPT)
			rem_q <= pulse_length;
		else if (fire && ctl.op == OP_SAMPLE && more)
			rem_q <= rem_q - ov;
		if (emit) begin
			if (ctl.op == OP_HDR) begin
				word_q  <= hdr_word;
				bytes_q <= HDR_BYTES;
				hdr_q   <= 1'b1;
				last_q  <= 1'b0;
				trunc_q <= 1'b0;
			end else begin
				word_q  <= ge ? ov : rem_q;
				bytes_q <= nbytes;
				hdr_q   <= 1'b0;
				last_q  <= !more;
				trunc_q <= ge && at_lim;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign word_data  = word_q;
	assign byte_count = bytes_q;
	assign is_header  = hdr_q;
	assign last_word  = last_q;
	assign truncated  = trunc_q;

`ifndef ASSERT_OFF
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && trunc_q |-> last_q && !hdr_q)
		else $error("truncated word not marked last");
	a_hdr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hdr_q |-> bytes_q == HDR_BYTES && !last_q)
		else $error("header word malformed");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LIM)
		else $error("chunk counter beyond limit");
	a_hdr_once: assert property (@(posedge clk) disable iff (!arst_n)
		header_done_q |=> header_done_q)
		else $error("header flag dropped");
`endif

endmodule

[src/tap_pulse_to_dmp_sample_packer.sv]
// Top level of the tape pulse to raw dump sample packer.
// Flow: the idle step takes a pulse, then each word is registered into the output register.
// Emit steps stall on a full output slot; no new pulse is taken until the last word of one is emitted.
// First pulse after reset adds five header words.
// Reset (arst_n low, async): sequencer to idle, config registers, counter and valid flag to defaults, header re-armed.
// No clearing pass; ready for a pulse straight out of reset.
module tap_pulse_to_dmp_sample_packer import tpdsp_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// pulse input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pulse_length,
	// word output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word_data,
	output logic [2:0]  byte_count,
	output logic        is_header,
	output logic        last_word,
	output logic        truncated
);

	ucode_t     ctl;
	logic       fire;
	dp_status_t status;

	// Sequencer: idle step takes a pulse, header steps run once, then the
	// sample step loops while overflow words remain under the chunk limit.
	tpdsp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctl      (ctl),
		.fire     (fire)
	);

	// Only the idle step takes a word; emit steps stall on a full output slot.
	assign in_ready = (ctl.op == OP_ACCEPT);

	tpdsp_dp #(
		.MAX_CHUNKS (MAX_CHUNKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pulse_length (pulse_length),
		.ctl          (ctl),
		.fire         (fire),
		.out_ready    (out_ready),
		.status       (status),
		.out_valid    (out_valid),
		.word_data    (word_data),
		.byte_count   (byte_count),
		.is_header    (is_header),
		.last_word    (last_word),
		.truncated    (truncated)
	);

endmodule
